@@ hdl/at_cmr_pkg.sv @@
// Shared types, constants and command/reply tables for the AT command responder.
`default_nettype none

package at_cmr_pkg;

    localparam int CMD_COUNT = 15;
    localparam int PFX_MAX   = 13;
    localparam int REPLY_MAX = 22;

    typedef logic [7:0]             t_rx;
    typedef logic [6:0]             t_char;
    typedef logic [3:0]             t_cmd_idx;
    typedef logic [4:0]             t_ridx;
    typedef logic [PFX_MAX*8-1:0]   t_pfx;
    typedef logic [REPLY_MAX*8-1:0] t_rtext;

    localparam logic [7:0] C_CR  = 8'h0D;
    localparam logic [7:0] C_LF  = 8'h0A;
    localparam t_char      CH_CR  = 7'h0D;
    localparam t_char      CH_SUB = 7'h1A;

    // command that switches to message mode
    localparam t_cmd_idx CMD_ARM = 4'd14;

    typedef enum logic [3:0] {
        RP_OK,
        RP_ZERO,
        RP_CPIN,
        RP_CREG,
        RP_COPS,
        RP_CSQ,
        RP_CPMS,
        RP_PROMPT,
        RP_CMGS
    } t_reply;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_TREAD,
        S_TSEND,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic take;
        logic decide;
        logic text_rd;
        logic text_send;
        logic reply_send;
    } t_dp_cmd;

    typedef struct packed {
        logic is_term;
        logic go_text;
        logic text_last;
        logic reply_last;
        logic out_free;
    } t_dp_stat;

    // prefixes, right aligned
    function automatic t_pfx cmd_pfx(input t_cmd_idx idx);
        case (idx)
            4'd0:    cmd_pfx = t_pfx'({"AT", C_CR});
            4'd1:    cmd_pfx = t_pfx'("ATE0V0X0");
            4'd2:    cmd_pfx = t_pfx'("AT+IPR=9600");
            4'd3:    cmd_pfx = t_pfx'("AT+CPIN?");
            4'd4:    cmd_pfx = t_pfx'("AT+CREG?");
            4'd5:    cmd_pfx = t_pfx'("ATS0=0+CMGF=1");
            4'd6:    cmd_pfx = t_pfx'("AT+COPS=3,0");
            4'd7:    cmd_pfx = t_pfx'("AT+COPS?");
            4'd8:    cmd_pfx = t_pfx'("AT+CSQ");
            4'd9:    cmd_pfx = t_pfx'("AT+CPMS?");
            4'd10:   cmd_pfx = t_pfx'("AT+CMGF=1");
            4'd11:   cmd_pfx = t_pfx'("AT+CMEE=1");
            4'd12:   cmd_pfx = t_pfx'("AT+CMEE=0");
            4'd13:   cmd_pfx = t_pfx'("at+csca=");
            4'd14:   cmd_pfx = t_pfx'("at+cmgs=");
            default: cmd_pfx = '0;
        endcase
    endfunction

    function automatic logic [3:0] cmd_plen(input t_cmd_idx idx);
        case (idx)
            4'd0:    cmd_plen = 4'd3;
            4'd1:    cmd_plen = 4'd8;
            4'd2:    cmd_plen = 4'd11;
            4'd3:    cmd_plen = 4'd8;
            4'd4:    cmd_plen = 4'd8;
            4'd5:    cmd_plen = 4'd13;
            4'd6:    cmd_plen = 4'd11;
            4'd7:    cmd_plen = 4'd8;
            4'd8:    cmd_plen = 4'd6;
            4'd9:    cmd_plen = 4'd8;
            4'd10:   cmd_plen = 4'd9;
            4'd11:   cmd_plen = 4'd9;
            4'd12:   cmd_plen = 4'd9;
            4'd13:   cmd_plen = 4'd8;
            4'd14:   cmd_plen = 4'd8;
            default: cmd_plen = 4'd0;
        endcase
    endfunction

    function automatic t_reply cmd_reply(input t_cmd_idx idx);
        case (idx)
            4'd0:    cmd_reply = RP_OK;
            4'd3:    cmd_reply = RP_CPIN;
            4'd4:    cmd_reply = RP_CREG;
            4'd7:    cmd_reply = RP_COPS;
            4'd8:    cmd_reply = RP_CSQ;
            4'd9:    cmd_reply = RP_CPMS;
            4'd14:   cmd_reply = RP_PROMPT;
            default: cmd_reply = RP_ZERO;
        endcase
    endfunction

    function automatic t_char cmd_char(input t_cmd_idx idx, input logic [3:0] pos);
        t_pfx p;
        int   sh;
        p  = cmd_pfx(idx);
        sh = (int'(cmd_plen(idx)) - 1 - int'(pos)) * 8;
        if (sh < 0) begin
            cmd_char = '0;
        end else begin
            cmd_char = p[sh +: 7];
        end
    endfunction

    function automatic t_rtext reply_text(input t_reply rp);
        case (rp)
            RP_OK:     reply_text = t_rtext'({"OK", C_CR, C_LF});
            RP_ZERO:   reply_text = t_rtext'({"0", C_CR});
            RP_CPIN:   reply_text = t_rtext'({"+CPIN: READY", C_CR});
            RP_CREG:   reply_text = t_rtext'({"+CREG: 1,1", C_CR});
            RP_COPS:   reply_text = t_rtext'({"+COPS: 2,0,0", C_CR});
            RP_CSQ:    reply_text = t_rtext'({"+CSQ: 15,2", C_CR});
            RP_CPMS:   reply_text = t_rtext'({"+CPMS: 2,10,2,10,2,10", C_CR});
            RP_PROMPT: reply_text = t_rtext'({C_CR, C_LF, " "});
            RP_CMGS:   reply_text = t_rtext'({"+CMGS: 42", C_CR});
            default:   reply_text = '0;
        endcase
    endfunction

    function automatic t_ridx reply_len(input t_reply rp);
        case (rp)
            RP_OK:     reply_len = 5'd4;
            RP_ZERO:   reply_len = 5'd2;
            RP_CPIN:   reply_len = 5'd13;
            RP_CREG:   reply_len = 5'd11;
            RP_COPS:   reply_len = 5'd13;
            RP_CSQ:    reply_len = 5'd11;
            RP_CPMS:   reply_len = 5'd22;
            RP_PROMPT: reply_len = 5'd3;
            RP_CMGS:   reply_len = 5'd10;
            default:   reply_len = 5'd1;
        endcase
    endfunction

    function automatic t_char reply_char(input t_reply rp, input t_ridx idx);
        t_rtext t;
        int     sh;
        t  = reply_text(rp);
        sh = (int'(reply_len(rp)) - 1 - int'(idx)) * 8;
        if (sh < 0) begin
            reply_char = '0;
        end else begin
            reply_char = t[sh +: 7];
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/at_cmr_if.sv @@
// Request channel interfaces: received bytes in, reply bytes out.
`default_nettype none

interface at_cmr_in_if;
    logic             valid;
    logic             ready;
    at_cmr_pkg::t_rx  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface at_cmr_out_if;
    logic               valid;
    logic               ready;
    at_cmr_pkg::t_char  out_byte;
    logic               out_kind;
    logic               run_end;

    modport source (output valid, output out_byte, output out_kind, output run_end,
                    input ready);
    modport sink   (input valid, input out_byte, input out_kind, input run_end,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/at_command_modem_responder.sv @@
// Top level of the AT command modem responder.
//
//   Channel   Dir   Payload                         Meaning
//   i_rx      in    rx_byte[7:0]                    received serial byte
//   o_tx      out   out_byte[6:0] out_kind run_end  reply or message text byte
//
// A byte that is ignored or gathered into the line is taken while idle. A
// terminator starts a decide step, then, only on a send confirmation, the
// message text (T bytes, 1..LINE_LEN-1) and then the reply (R bytes,
// 2..22): each text byte is one line store read plus one send.
// The controller handles one request at a time; i_rx.ready is high only idle.
// Reset (synchronous, active low) clears line length, mode and the output
// valid and sets all match flags; the line store itself needs no clearing.
// Stalls on o_tx hold the output register and pause the run in place.
`default_nettype none

module at_command_modem_responder #(
    parameter int LINE_LEN = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    at_cmr_in_if.sink     i_rx,
    at_cmr_out_if.source  o_tx
);
    import at_cmr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    // Controller: idle takes bytes; a terminator starts decide, then the
    // optional message text run and the fixed reply run.
    at_cmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: line store memory, per-command prefix match flags updated as
    // bytes land, mode bit, sequencing counters and the output register.
    at_cmr_datapath #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_rx_byte     (i_rx.rx_byte),
        .i_out_ready   (o_tx.ready),
        .o_out_valid   (o_tx.valid),
        .o_out_byte    (o_tx.out_byte),
        .o_out_kind    (o_tx.out_kind),
        .o_out_run_end (o_tx.run_end)
    );

    assign i_rx.ready = in_ready;

endmodule

`default_nettype wire

@@ hdl/at_cmr_datapath.sv @@
// Datapath: line store, running prefix match, reply/text sequencing, output register.
`default_nettype none

module at_cmr_datapath #(
    parameter int LINE_LEN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  at_cmr_pkg::t_dp_cmd  i_cmd,
    output at_cmr_pkg::t_dp_stat o_stat,
    input  at_cmr_pkg::t_rx      i_rx_byte,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output at_cmr_pkg::t_char    o_out_byte,
    output logic                 o_out_kind,
    output logic                 o_out_run_end
);
    import at_cmr_pkg::*;

    localparam int LW = $clog2(LINE_LEN + 1);
    localparam int AW = $clog2(LINE_LEN);
    localparam logic [LW-1:0] LEN_KEEP = LW'(LINE_LEN - 1);

    t_char                r_line [LINE_LEN];
    t_char                r_rd_data;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        r_mlen;
    logic [LW-1:0]        r_tidx;
    t_ridx                r_ridx;
    logic [CMD_COUNT-1:0] r_match;
    logic                 r_mode;
    t_reply               r_reply;
    logic                 r_out_valid;
    t_char                r_out_byte;
    logic                 r_out_kind;
    logic                 r_out_end;

    t_char                rx_char;
    logic                 rx_ok;
    logic                 is_term;
    t_char                st_char;
    logic                 do_store;
    logic [CMD_COUNT-1:0] n_match;
    logic [CMD_COUNT-1:0] hit;
    logic                 any_hit;
    t_cmd_idx             hit_idx;
    logic                 text_last;
    logic                 reply_last;
    logic                 out_free;

    assign rx_char  = i_rx_byte[6:0];
    assign rx_ok    = !i_rx_byte[7] && (rx_char != '0);
    assign is_term  = rx_ok && (rx_char == (r_mode ? CH_SUB : CH_CR));
    // CR closing a command line is kept; SUB closing a message is not
    assign st_char  = is_term ? CH_CR : rx_char;
    assign do_store = i_cmd.take && rx_ok && (is_term ? !r_mode : (r_len < LEN_KEEP));

    // each stored byte narrows the set of prefixes still in the running
    always_comb begin
        for (int i = 0; i < CMD_COUNT; i++) begin
            n_match[i] = r_match[i] &&
                         ((r_len >= LW'(cmd_plen(t_cmd_idx'(i)))) ||
                          (st_char == cmd_char(t_cmd_idx'(i), r_len[3:0])));
            hit[i]     = r_match[i] && (r_mlen >= LW'(cmd_plen(t_cmd_idx'(i))));
        end
    end

    // first hit in table order wins
    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = CMD_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                any_hit = 1'b1;
                hit_idx = t_cmd_idx'(i);
            end
        end
    end

    assign text_last  = (r_tidx + LW'(1)) == r_mlen;
    assign reply_last = (r_ridx + t_ridx'(1)) == reply_len(r_reply);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.is_term    = is_term;
        o_stat.go_text    = !any_hit && r_mode && (r_mlen != '0);
        o_stat.text_last  = text_last;
        o_stat.reply_last = reply_last;
        o_stat.out_free   = out_free;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_line[r_len[AW-1:0]] <= st_char;
        end
        if (i_cmd.text_rd) begin
            r_rd_data <= r_line[r_tidx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_match     <= '1;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take && rx_ok) begin
                if (is_term) begin
                    r_len <= '0;
                end else if (r_len < LEN_KEEP) begin
                    r_len <= r_len + LW'(1);
                end
            end
            if (do_store) begin
                r_match <= n_match;
            end
            if (i_cmd.decide) begin
                r_match <= '1;
                if (any_hit && (hit_idx == CMD_ARM)) begin
                    r_mode <= 1'b1;
                end else if (!any_hit) begin
                    r_mode <= 1'b0;
                end
            end
            if (i_cmd.text_send || i_cmd.reply_send) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_term) begin
            r_mlen <= r_mode ? r_len : r_len + LW'(1);
        end
        if (i_cmd.decide) begin
            r_reply <= any_hit ? cmd_reply(hit_idx) : (r_mode ? RP_CMGS : RP_ZERO);
            r_tidx  <= '0;
            r_ridx  <= '0;
        end
        if (i_cmd.text_send) begin
            r_tidx     <= r_tidx + LW'(1);
            r_out_byte <= r_rd_data;
            r_out_kind <= 1'b1;
            r_out_end  <= 1'b0;
        end
        if (i_cmd.reply_send) begin
            r_ridx     <= r_ridx + t_ridx'(1);
            r_out_byte <= reply_char(r_reply, r_ridx);
            r_out_kind <= 1'b0;
            r_out_end  <= reply_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_kind    = r_out_kind;
    assign o_out_run_end = r_out_end;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_KEEP)
        else $error("line length past store capacity");

    a_text_only_cmgs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.text_send |-> (r_reply == RP_CMGS))
        else $error("message text sent outside a send confirmation run");

    a_arm_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && any_hit && (hit_idx == CMD_ARM)) |=> r_mode)
        else $error("message mode not entered after send command");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && is_term) |=> (r_len == '0))
        else $error("line not cleared after terminator");

endmodule

`default_nettype wire

@@ hdl/at_cmr_ctrl.sv @@
// Controller state machine: takes bytes, then sequences text and reply runs.
`default_nettype none

module at_cmr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  at_cmr_pkg::t_dp_stat i_stat,
    output at_cmr_pkg::t_dp_cmd  o_cmd
);
    import at_cmr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.is_term) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.go_text ? S_TREAD : S_REPLY;
            end
            S_TREAD: begin
                o_cmd.text_rd = 1'b1;
                n_state       = S_TSEND;
            end
            S_TSEND: begin
                if (i_stat.out_free) begin
                    o_cmd.text_send = 1'b1;
                    n_state         = i_stat.text_last ? S_REPLY : S_TREAD;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.reply_send = 1'b1;
                    if (i_stat.reply_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
